### sv/time_sorted_sample_buffer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted sample buffer
// ---------------------------------------------------------------------------
`ifndef TIME_SORTED_SAMPLE_BUFFER_MACROS_SVH
`define TIME_SORTED_SAMPLE_BUFFER_MACROS_SVH

// same-cycle implication
`define TSSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TSSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/tssb_pkg.sv
// ---------------------------------------------------------------------------
// tssb_pkg
// Shared widths, request and status codes, and defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tssb_pkg;

  localparam int STAMP_W     = 63;
  localparam int FRAME_PW    = 16;
  localparam int PAYLOAD_W   = 32;
  localparam int AGE_W       = 40;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 4;
  localparam int NFOUND_W    = 2;

  localparam int DEPTH_DEF      = 64;
  localparam int FRAME_BITS_DEF = 16;

  localparam logic [AGE_W-1:0] AGE_RESET = 40'd10000000000;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ONE      = 4'd0;
  localparam logic [STATUS_W-1:0] ST_PAIR     = 4'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FUTURE   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_PAST     = 4'd5;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 4'd8;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 4'd9;

  localparam logic [NFOUND_W-1:0] NF_NONE = 2'd0;
  localparam logic [NFOUND_W-1:0] NF_ONE  = 2'd1;
  localparam logic [NFOUND_W-1:0] NF_TWO  = 2'd2;

endpackage

### sv/tssb_ifs.sv
// ---------------------------------------------------------------------------
// tssb channel interfaces
// Request, result and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tssb_in_if;
  logic                              valid;
  logic                              ready;
  logic [tssb_pkg::REQ_W-1:0]        req_type;
  logic [tssb_pkg::STAMP_W-1:0]      stamp;
  logic [tssb_pkg::FRAME_PW-1:0]     parent_id;
  logic [tssb_pkg::FRAME_PW-1:0]     child_id;
  logic [tssb_pkg::PAYLOAD_W-1:0]    payload;
  modport source (output valid, req_type, stamp, parent_id, child_id, payload,
                  input ready);
  modport sink   (input valid, req_type, stamp, parent_id, child_id, payload,
                  output ready);
endinterface

interface tssb_out_if #(parameter int CNT_W = 7);
  logic                              valid;
  logic                              ready;
  logic [tssb_pkg::STATUS_W-1:0]     status;
  logic [tssb_pkg::NFOUND_W-1:0]     n_found;
  logic [tssb_pkg::PAYLOAD_W-1:0]    older_payload;
  logic [tssb_pkg::PAYLOAD_W-1:0]    newer_payload;
  logic [tssb_pkg::STAMP_W-1:0]      older_stamp;
  logic [tssb_pkg::STAMP_W-1:0]      newer_stamp;
  logic [tssb_pkg::FRAME_PW-1:0]     parent_frame;
  logic                              interpolate;
  logic [CNT_W-1:0]                  entries;
  logic [tssb_pkg::STAMP_W-1:0]      latest_stamp;
  logic [tssb_pkg::STAMP_W-1:0]      oldest_stamp;
  modport source (output valid, status, n_found, older_payload, newer_payload,
                  older_stamp, newer_stamp, parent_frame, interpolate, entries,
                  latest_stamp, oldest_stamp, input ready);
  modport sink   (input valid, status, n_found, older_payload, newer_payload,
                  older_stamp, newer_stamp, parent_frame, interpolate, entries,
                  latest_stamp, oldest_stamp, output ready);
endinterface

interface tssb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tssb_pkg::AGE_W-1:0]     data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/tssb_cell.sv
// ---------------------------------------------------------------------------
// tssb_cell
// One buffer slot; takes its neighbor's entry on every shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tssb_cell #(
  parameter int FRAME_BITS = tssb_pkg::FRAME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           shift_en,
  input  logic [tssb_pkg::STAMP_W-1:0]   d_stamp,
  input  logic [FRAME_BITS-1:0]          d_parent,
  input  logic [FRAME_BITS-1:0]          d_child,
  input  logic [tssb_pkg::PAYLOAD_W-1:0] d_payload,
  output logic [tssb_pkg::STAMP_W-1:0]   q_stamp,
  output logic [FRAME_BITS-1:0]          q_parent,
  output logic [FRAME_BITS-1:0]          q_child,
  output logic [tssb_pkg::PAYLOAD_W-1:0] q_payload
);

  logic [tssb_pkg::STAMP_W-1:0]   stamp_r;
  logic [FRAME_BITS-1:0]          parent_r;
  logic [FRAME_BITS-1:0]          child_r;
  logic [tssb_pkg::PAYLOAD_W-1:0] payload_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      stamp_r   <= d_stamp;
      parent_r  <= d_parent;
      child_r   <= d_child;
      payload_r <= d_payload;
    end
  end

  assign q_stamp   = stamp_r;
  assign q_parent  = parent_r;
  assign q_child   = child_r;
  assign q_payload = payload_r;

endmodule

### sv/time_sorted_sample_buffer.sv
// ---------------------------------------------------------------------------
// time_sorted_sample_buffer
// Newest-first stamp buffer with age pruning, insert/lookup/clear requests.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per beat (insert, lookup, clear). Request code
//   3 is taken and dropped without a result. out_ch returns one result beat
//   per other request. cfg_ch writes max_age; write it only while idle.
//   Entries live in a ring of DEPTH cells. Every insert, lookup or clear
//   request rotates the ring once around, one cell per cycle, while a
//   sequencer at the head compares, inserts, updates, prunes and gathers
//   lookup data. A request passes ST_SCAN, then ST_FINISH, which loads the
//   result register. One request is in flight at a time; in_ch.ready is
//   high only while idle, so a new request waits until the last leaves ST_FINISH.
//   A result waits in the output register while out_ch is stalled; the next
//   request may be accepted meanwhile, and its result waits for the slot.
//   Reset empties the buffer (count to zero) and sets max_age to 10 s.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "time_sorted_sample_buffer_macros.svh"

module time_sorted_sample_buffer #(
  parameter int DEPTH      = tssb_pkg::DEPTH_DEF,
  parameter int FRAME_BITS = tssb_pkg::FRAME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tssb_in_if.sink       in_ch,
  tssb_out_if.source    out_ch,
  tssb_cfg_if.sink      cfg_ch
);

  localparam int SW    = tssb_pkg::STAMP_W;
  localparam int SW1   = SW + 1;
  localparam int PW    = tssb_pkg::PAYLOAD_W;
  localparam int FPW   = tssb_pkg::FRAME_PW;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  typedef struct packed {
    logic [tssb_pkg::STATUS_W-1:0] status;
    logic [tssb_pkg::NFOUND_W-1:0] n_found;
    logic [PW-1:0]                 older_payload;
    logic [PW-1:0]                 newer_payload;
    logic [SW-1:0]                 older_stamp;
    logic [SW-1:0]                 newer_stamp;
    logic [FPW-1:0]                parent_frame;
    logic                          interpolate;
    logic [CNT_W-1:0]              entries;
    logic [SW-1:0]                 latest_stamp;
    logic [SW-1:0]                 oldest_stamp;
  } res_t;

  // ring of cells
  logic [SW-1:0]         c_stamp   [DEPTH];
  logic [FRAME_BITS-1:0] c_parent  [DEPTH];
  logic [FRAME_BITS-1:0] c_child   [DEPTH];
  logic [PW-1:0]         c_payload [DEPTH];
  logic [SW-1:0]         n_stamp   [DEPTH];
  logic [FRAME_BITS-1:0] n_parent  [DEPTH];
  logic [FRAME_BITS-1:0] n_child   [DEPTH];
  logic [PW-1:0]         n_payload [DEPTH];
  logic                  shift_en;

  logic [SW-1:0]         em_stamp;
  logic [FRAME_BITS-1:0] em_parent;
  logic [FRAME_BITS-1:0] em_child;
  logic [PW-1:0]         em_payload;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_tail
        assign n_stamp[g]   = em_stamp;
        assign n_parent[g]  = em_parent;
        assign n_child[g]   = em_child;
        assign n_payload[g] = em_payload;
      end else begin : g_mid
        assign n_stamp[g]   = c_stamp[g+1];
        assign n_parent[g]  = c_parent[g+1];
        assign n_child[g]   = c_child[g+1];
        assign n_payload[g] = c_payload[g+1];
      end
      tssb_cell #(.FRAME_BITS(FRAME_BITS)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_stamp  (n_stamp[g]),
        .d_parent (n_parent[g]),
        .d_child  (n_child[g]),
        .d_payload(n_payload[g]),
        .q_stamp  (c_stamp[g]),
        .q_parent (c_parent[g]),
        .q_child  (c_child[g]),
        .q_payload(c_payload[g])
      );
    end
  endgenerate

  // control and request registers
  state_t                      state_r;
  logic [IDX_W-1:0]            step_r;
  logic [CNT_W-1:0]            count_r;
  logic [tssb_pkg::AGE_W-1:0]  age_r;
  logic [tssb_pkg::REQ_W-1:0]  req_r;
  logic [SW-1:0]               st_r;
  logic [FRAME_BITS-1:0]       fr_r;
  logic [FRAME_BITS-1:0]       ch_r;
  logic [PW-1:0]               pl_r;
  logic [SW-1:0]               newest_r;
  logic                        rej_r;
  logic                        done_r, upd_r, ins_r, carry_r;
  logic [SW-1:0]               cy_stamp_r;
  logic [FRAME_BITS-1:0]       cy_parent_r, cy_child_r;
  logic [PW-1:0]               cy_payload_r;
  logic [CNT_W-1:0]            keep_cnt_r;
  logic [SW-1:0]               keep_old_r;
  logic [SW-1:0]               first_stamp_r;
  logic [PW-1:0]               f_pay_r;
  logic [FRAME_BITS-1:0]       f_par_r;
  logic [SW-1:0]               l_stamp_r;
  logic [PW-1:0]               l_pay_r;
  logic [FRAME_BITS-1:0]       l_par_r;
  logic [SW-1:0]               pv_stamp_r;
  logic [PW-1:0]               pv_pay_r;
  logic [FRAME_BITS-1:0]       pv_par_r;
  logic                        found_r;
  logic [SW-1:0]               po_stamp_r, pn_stamp_r;
  logic [PW-1:0]               po_pay_r, pn_pay_r;
  logic [FRAME_BITS-1:0]       po_par_r, pn_par_r;
  logic                        out_valid_r;
  res_t                        res_r;
  res_t                        res_nxt;
  logic [CNT_W-1:0]            count_nxt;

  logic [SW-1:0]         h_stamp;
  logic [FRAME_BITS-1:0] h_parent, h_child;
  logic [PW-1:0]         h_payload;
  logic [CNT_W-1:0]      kx;
  logic [CNT_W-1:0]      last_idx;
  logic                  in_range, mod_mode, ins_now, upd_now, real_pos, keep_ok;
  logic                  in_acc, out_acc, fin_load, start_scan;
  logic [SW-1:0]         in_stamp;

  assign h_stamp   = c_stamp[0];
  assign h_parent  = c_parent[0];
  assign h_child   = c_child[0];
  assign h_payload = c_payload[0];

  assign in_stamp  = in_ch.stamp;
  assign kx        = CNT_W'(step_r);
  assign last_idx  = count_r - CNT_W'(1);
  assign in_range  = kx < count_r;
  assign mod_mode  = (req_r == tssb_pkg::REQ_INSERT) && !rej_r;
  assign shift_en  = (state_r == ST_SCAN);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_acc    = out_valid_r && out_ch.ready;
  assign fin_load   = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);
  assign start_scan = in_acc && (in_ch.req_type != tssb_pkg::REQ_NONE);

  // what the head position becomes on this rotation step
  always_comb begin
    em_stamp   = h_stamp;
    em_parent  = h_parent;
    em_child   = h_child;
    em_payload = h_payload;
    ins_now    = 1'b0;
    upd_now    = 1'b0;
    if (mod_mode) begin
      if (carry_r) begin
        em_stamp   = cy_stamp_r;
        em_parent  = cy_parent_r;
        em_child   = cy_child_r;
        em_payload = cy_payload_r;
      end else if (!done_r && in_range && h_stamp == st_r &&
                   h_parent == fr_r && h_child == ch_r) begin
        em_payload = pl_r;
        upd_now    = 1'b1;
      end else if (!done_r && (!in_range || h_stamp < st_r)) begin
        em_stamp   = st_r;
        em_parent  = fr_r;
        em_child   = ch_r;
        em_payload = pl_r;
        ins_now    = 1'b1;
      end
    end
  end

  assign real_pos = in_range || (kx == count_r && (ins_now || ins_r));
  assign keep_ok  = (SW1'(em_stamp) + SW1'(age_r)) >= SW1'(newest_r);

  // result assembly
  always_comb begin
    logic use_keep;
    res_nxt   = '0;
    use_keep  = 1'b0;
    count_nxt = count_r;
    case (req_r)
      tssb_pkg::REQ_INSERT: begin
        if (rej_r) begin
          res_nxt.status = tssb_pkg::ST_REJECTED;
        end else if (upd_r) begin
          res_nxt.status = tssb_pkg::ST_UPDATED;
        end else if (ins_r) begin
          res_nxt.status = tssb_pkg::ST_INSERTED;
          count_nxt      = keep_cnt_r;
          use_keep       = 1'b1;
        end else begin
          res_nxt.status = tssb_pkg::ST_REJECTED;   // full, new entry oldest
        end
      end
      tssb_pkg::REQ_LOOKUP: begin
        if (count_r == '0) begin
          res_nxt.status = tssb_pkg::ST_EMPTY;
        end else if (st_r == '0 || st_r == first_stamp_r) begin
          res_nxt.status        = tssb_pkg::ST_ONE;
          res_nxt.n_found       = tssb_pkg::NF_ONE;
          res_nxt.older_payload = f_pay_r;
          res_nxt.older_stamp   = first_stamp_r;
          res_nxt.parent_frame  = FPW'(f_par_r);
        end else if (count_r == CNT_W'(1)) begin
          res_nxt.status = tssb_pkg::ST_MISMATCH;
        end else if (st_r == l_stamp_r) begin
          res_nxt.status        = tssb_pkg::ST_ONE;
          res_nxt.n_found       = tssb_pkg::NF_ONE;
          res_nxt.older_payload = l_pay_r;
          res_nxt.older_stamp   = l_stamp_r;
          res_nxt.parent_frame  = FPW'(l_par_r);
        end else if (st_r > first_stamp_r) begin
          res_nxt.status = tssb_pkg::ST_FUTURE;
        end else if (st_r < l_stamp_r) begin
          res_nxt.status = tssb_pkg::ST_PAST;
        end else begin
          res_nxt.status        = tssb_pkg::ST_PAIR;
          res_nxt.n_found       = tssb_pkg::NF_TWO;
          res_nxt.older_payload = po_pay_r;
          res_nxt.newer_payload = pn_pay_r;
          res_nxt.older_stamp   = po_stamp_r;
          res_nxt.newer_stamp   = pn_stamp_r;
          res_nxt.parent_frame  = FPW'(po_par_r);
          res_nxt.interpolate   = (po_par_r == pn_par_r);
        end
      end
      tssb_pkg::REQ_CLEAR: begin
        res_nxt.status = tssb_pkg::ST_CLEARED;
        count_nxt      = '0;
      end
      default: begin
        res_nxt.status = tssb_pkg::ST_REJECTED;
      end
    endcase
    res_nxt.entries = count_nxt;
    if (count_nxt != '0) begin
      res_nxt.latest_stamp = first_stamp_r;
      res_nxt.oldest_stamp = use_keep ? keep_old_r : l_stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      age_r       <= tssb_pkg::AGE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        age_r <= cfg_ch.data;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r      <= in_ch.req_type;
            st_r       <= in_stamp;
            fr_r       <= FRAME_BITS'(in_ch.parent_id);
            ch_r       <= FRAME_BITS'(in_ch.child_id);
            pl_r       <= in_ch.payload;
            rej_r      <= (count_r != '0) &&
                          (SW1'(h_stamp) > SW1'(in_stamp) + SW1'(age_r));
            newest_r   <= (count_r != '0 && h_stamp >= in_stamp) ? h_stamp : in_stamp;
            done_r     <= 1'b0;
            upd_r      <= 1'b0;
            ins_r      <= 1'b0;
            carry_r    <= 1'b0;
            found_r    <= 1'b0;
            keep_cnt_r <= '0;
            if (in_ch.req_type != tssb_pkg::REQ_NONE) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          carry_r <= carry_r | ins_now;
          done_r  <= done_r | ins_now | upd_now;
          upd_r   <= upd_r | upd_now;
          ins_r   <= ins_r | ins_now;
          if (carry_r || ins_now) begin
            cy_stamp_r   <= h_stamp;
            cy_parent_r  <= h_parent;
            cy_child_r   <= h_child;
            cy_payload_r <= h_payload;
          end
          // kept entries form a prefix, so the last kept one is the oldest
          if (real_pos && keep_ok) begin
            keep_cnt_r <= keep_cnt_r + CNT_W'(1);
            keep_old_r <= em_stamp;
          end
          if (step_r == '0) begin
            first_stamp_r <= em_stamp;
            f_pay_r       <= h_payload;
            f_par_r       <= h_parent;
          end
          if (kx == last_idx) begin
            l_stamp_r <= h_stamp;
            l_pay_r   <= h_payload;
            l_par_r   <= h_parent;
          end
          pv_stamp_r <= h_stamp;
          pv_pay_r   <= h_payload;
          pv_par_r   <= h_parent;
          // bracketing pair: first entry at or below the stamp, stop at the last
          if (!found_r && step_r != '0 && in_range &&
              (h_stamp <= st_r || kx == last_idx)) begin
            found_r    <= 1'b1;
            po_stamp_r <= h_stamp;
            po_pay_r   <= h_payload;
            po_par_r   <= h_parent;
            pn_stamp_r <= pv_stamp_r;
            pn_pay_r   <= pv_pay_r;
            pn_par_r   <= pv_par_r;
          end
          if (step_r == IDX_W'(DEPTH - 1)) begin
            step_r  <= '0;
            state_r <= ST_FINISH;
          end else begin
            step_r <= step_r + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (fin_load) begin
            count_r <= count_nxt;
            res_r   <= res_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.n_found       = res_r.n_found;
  assign out_ch.older_payload = res_r.older_payload;
  assign out_ch.newer_payload = res_r.newer_payload;
  assign out_ch.older_stamp   = res_r.older_stamp;
  assign out_ch.newer_stamp   = res_r.newer_stamp;
  assign out_ch.parent_frame  = res_r.parent_frame;
  assign out_ch.interpolate   = res_r.interpolate;
  assign out_ch.entries       = res_r.entries;
  assign out_ch.latest_stamp  = res_r.latest_stamp;
  assign out_ch.oldest_stamp  = res_r.oldest_stamp;

  `TSSB_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `TSSB_ASSERT_NOW(a_step_idle, clk, rst_n, state_r != ST_SCAN, step_r == '0)
  `TSSB_ASSERT_NEXT(a_accept_scan, clk, rst_n, start_scan, state_r == ST_SCAN)
  `TSSB_ASSERT_NEXT(a_finish_out, clk, rst_n, fin_load, out_valid_r && state_r == ST_IDLE)

endmodule

### bench/time_sorted_sample_buffer_tb.sv
// ---------------------------------------------------------------------------
// time_sorted_sample_buffer_tb
// Drives insert, lookup and clear requests into the sorted sample buffer,
// predicts every result beat from an internal copy of the buffer contents
// and compares each one field by field, over several storage windows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_sorted_sample_buffer_tb;

  localparam int SLOTS     = 64;
  localparam int REQ_W     = tssb_pkg::REQ_W;
  localparam int STAMP_W   = tssb_pkg::STAMP_W;
  localparam int FRAME_PW  = tssb_pkg::FRAME_PW;
  localparam int PAYLOAD_W = tssb_pkg::PAYLOAD_W;
  localparam int STATUS_W  = tssb_pkg::STATUS_W;
  localparam int NFOUND_W  = tssb_pkg::NFOUND_W;
  localparam int AGE_W     = tssb_pkg::AGE_W;

  typedef struct packed {
    logic [REQ_W-1:0]     kind;
    logic [STAMP_W-1:0]   stamp;
    logic [FRAME_PW-1:0]  parent;
    logic [FRAME_PW-1:0]  child;
    logic [PAYLOAD_W-1:0] handle;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [NFOUND_W-1:0]  n_found;
    logic [PAYLOAD_W-1:0] older_payload;
    logic [PAYLOAD_W-1:0] newer_payload;
    logic [STAMP_W-1:0]   older_stamp;
    logic [STAMP_W-1:0]   newer_stamp;
    logic [FRAME_PW-1:0]  parent_frame;
    logic                 interpolate;
    logic [6:0]           entries;
    logic [STAMP_W-1:0]   latest_stamp;
    logic [STAMP_W-1:0]   oldest_stamp;
  } response_t;

  logic clk;
  logic rst_n;

  tssb_in_if              in_ch ();
  tssb_out_if #(.CNT_W(7)) out_ch ();
  tssb_cfg_if             cfg_ch ();

  time_sorted_sample_buffer #(.DEPTH(SLOTS), .FRAME_BITS(16)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow buffer, newest first
  logic [STAMP_W-1:0]   sh_stamp  [SLOTS];
  logic [FRAME_PW-1:0]  sh_parent [SLOTS];
  logic [FRAME_PW-1:0]  sh_child  [SLOTS];
  logic [PAYLOAD_W-1:0] sh_handle [SLOTS];
  int                   sh_count;
  logic [AGE_W-1:0]     window_ns;

  request_t  request_q[$];
  response_t pending_responses[$];
  request_t  on_bus;
  int        accepted_count;
  int        mismatch_count;
  logic      tx_hold;
  logic      no_idle;
  logic      rx_hold;

  logic [STAMP_W-1:0] base_stamp;
  logic [STAMP_W-1:0] recent_stamps[$];

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic void set_found(inout response_t r, input int k);
    r.status        = tssb_pkg::ST_ONE;
    r.n_found       = tssb_pkg::NF_ONE;
    r.older_payload = sh_handle[k];
    r.older_stamp   = sh_stamp[k];
    r.parent_frame  = sh_parent[k];
  endfunction

  function automatic logic [STATUS_W-1:0] insert_sample(request_t q);
    int n, i, k;
    logic done;
    logic [63:0] lim;
    n = sh_count;
    i = 0;
    done = 1'b0;
    lim = {1'b0, q.stamp} + {24'd0, window_ns};
    if (n > 0 && {1'b0, sh_stamp[0]} > lim) return tssb_pkg::ST_REJECTED;
    while (i < n && !done) begin
      if (sh_stamp[i] < q.stamp) done = 1'b1;
      else if (sh_stamp[i] == q.stamp && sh_parent[i] == q.parent && sh_child[i] == q.child)
        begin
        sh_handle[i] = q.handle;
        return tssb_pkg::ST_UPDATED;
      end else i++;
    end
    if (n >= SLOTS) begin
      if (i >= SLOTS) return tssb_pkg::ST_REJECTED;
      n = SLOTS - 1;  // oldest falls off
    end
    for (k = n; k > i; k--) begin
      sh_stamp[k]  = sh_stamp[k-1];
      sh_parent[k] = sh_parent[k-1];
      sh_child[k]  = sh_child[k-1];
      sh_handle[k] = sh_handle[k-1];
    end
    sh_stamp[i]  = q.stamp;
    sh_parent[i] = q.parent;
    sh_child[i]  = q.child;
    sh_handle[i] = q.handle;
    n++;
    while (n > 0 && ({1'b0, sh_stamp[n-1]} + {24'd0, window_ns}) < {1'b0, sh_stamp[0]})
      n--;
    sh_count = n;
    return tssb_pkg::ST_INSERTED;
  endfunction

  function automatic void lookup_sample(logic [STAMP_W-1:0] t, inout response_t r);
    int n, i;
    n = sh_count;
    if (n == 0) begin
      r.status = tssb_pkg::ST_EMPTY;
    end else if (t == 0) begin
      set_found(r, 0);
    end else if (n == 1) begin
      if (sh_stamp[0] == t) set_found(r, 0);
      else r.status = tssb_pkg::ST_MISMATCH;
    end else if (t == sh_stamp[0]) begin
      set_found(r, 0);
    end else if (t == sh_stamp[n-1]) begin
      set_found(r, n - 1);
    end else if (t > sh_stamp[0]) begin
      r.status = tssb_pkg::ST_FUTURE;
    end else if (t < sh_stamp[n-1]) begin
      r.status = tssb_pkg::ST_PAST;
    end else begin
      i = 1;
      while (i < n - 1 && sh_stamp[i] > t) i++;
      r.status        = tssb_pkg::ST_PAIR;
      r.n_found       = tssb_pkg::NF_TWO;
      r.older_payload = sh_handle[i];
      r.newer_payload = sh_handle[i-1];
      r.older_stamp   = sh_stamp[i];
      r.newer_stamp   = sh_stamp[i-1];
      r.parent_frame  = sh_parent[i];
      r.interpolate   = (sh_parent[i] == sh_parent[i-1]);
    end
  endfunction

  function automatic response_t predict_response(request_t q);
    response_t r;
    r = '0;
    case (q.kind)
      tssb_pkg::REQ_INSERT: r.status = insert_sample(q);
      tssb_pkg::REQ_LOOKUP: lookup_sample(q.stamp, r);
      default: begin
        sh_count = 0;
        r.status = tssb_pkg::ST_CLEARED;
      end
    endcase
    r.entries = sh_count[6:0];
    if (sh_count > 0) begin
      r.latest_stamp = sh_stamp[0];
      r.oldest_stamp = sh_stamp[sh_count-1];
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_count++;
        if (on_bus.kind != tssb_pkg::REQ_NONE)
          pending_responses.push_back(predict_response(on_bus));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the beat
      end else if (!tx_hold && request_q.size() > 0 &&
                   (no_idle || $urandom_range(0, 99) >= 33)) begin
        on_bus = request_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= on_bus.kind;
        in_ch.stamp     <= on_bus.stamp;
        in_ch.parent_id <= on_bus.parent;
        in_ch.child_id  <= on_bus.child;
        in_ch.payload   <= on_bus.handle;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    response_t got, exp;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.n_found, out_ch.older_payload, out_ch.newer_payload,
                out_ch.older_stamp, out_ch.newer_stamp, out_ch.parent_frame,
                out_ch.interpolate, out_ch.entries, out_ch.latest_stamp,
                out_ch.oldest_stamp};
        if (pending_responses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat: %p", got);
        end else begin
          exp = pending_responses.pop_front();
          if (got !== exp) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch at %0t\n  exp %p\n  got %p", $realtime, exp, got);
          end
        end
      end
      out_ch.ready <= !rx_hold && (no_idle || $urandom_range(0, 99) >= 33);
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    while (accepted_count < 500) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (700) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_req(logic [REQ_W-1:0] kind, logic [STAMP_W-1:0] st,
                          logic [FRAME_PW-1:0] par, logic [FRAME_PW-1:0] chd,
                          logic [PAYLOAD_W-1:0] h);
    request_t q;
    q = '{kind, st, par, chd, h};
    request_q.push_back(q);
  endtask

  function automatic logic [STAMP_W-1:0] pick_stamp(logic for_lookup);
    int r;
    r = $urandom_range(0, 99);
    if (for_lookup && r < 10) return '0;
    if (r < 14) return STAMP_W'({$urandom, $urandom});
    if (r < 16) return '1;
    if (r < 50 && recent_stamps.size() > 0)
      return recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
    return base_stamp - $urandom_range(0, 3000) + $urandom_range(0, 400);
  endfunction

  function automatic request_t random_request();
    request_t q;
    int r;
    r = $urandom_range(0, 99);
    q.kind   = (r < 60) ? tssb_pkg::REQ_INSERT : (r < 95) ? tssb_pkg::REQ_LOOKUP :
               (r < 97) ? tssb_pkg::REQ_CLEAR : tssb_pkg::REQ_NONE;
    q.parent = ($urandom_range(0, 4) != 0) ? FRAME_PW'($urandom_range(0, 2))
                                           : FRAME_PW'($urandom);
    q.child  = ($urandom_range(0, 4) != 0) ? FRAME_PW'($urandom_range(0, 2))
                                           : FRAME_PW'($urandom);
    q.handle = $urandom;
    q.stamp  = pick_stamp(q.kind == tssb_pkg::REQ_LOOKUP);
    if (q.kind == tssb_pkg::REQ_INSERT) begin
      base_stamp = base_stamp + $urandom_range(0, 200);
      recent_stamps.push_back(q.stamp);
      if (recent_stamps.size() > 32) void'(recent_stamps.pop_front());
    end
    return q;
  endfunction

  // sampled at the falling edge, after the driver's updates have settled
  task automatic drain();
    while (request_q.size() > 0 || in_ch.valid || pending_responses.size() > 0)
      @(negedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_window(logic [AGE_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    window_ns = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [AGE_W-1:0] windows[5];
    int p, k;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.stamp = '0;
    in_ch.parent_id = '0;
    in_ch.child_id = '0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    sh_count = 0;
    window_ns = tssb_pkg::AGE_RESET;
    accepted_count = 0;
    mismatch_count = 0;
    tx_hold = 1'b0;
    no_idle = 1'b0;
    on_bus = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty, single entry, pairs, update, extremes, ignored code, clear
    push_req(tssb_pkg::REQ_LOOKUP, 63'd1000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_INSERT, 63'd5000, 16'd1, 16'd1, 32'h1111);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd5000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd6000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_INSERT, 63'd7000, 16'd1, 16'd2, 32'h2222);
    push_req(tssb_pkg::REQ_INSERT, 63'd9000, 16'd2, 16'd1, 32'h3333);
    push_req(tssb_pkg::REQ_INSERT, 63'd7000, 16'd1, 16'd2, 32'h4444);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd0, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd9000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd5000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd7000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd8000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd6000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd10000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd4000, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_INSERT, '1, '1, '1, '1);
    push_req(tssb_pkg::REQ_INSERT, 63'd0, 16'd3, 16'd3, 32'h5555);
    push_req(tssb_pkg::REQ_LOOKUP, '1, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_NONE, '1, '1, '1, '1);
    push_req(tssb_pkg::REQ_CLEAR, 63'd0, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd0, 16'd0, 16'd0, 32'd0);
    push_req(tssb_pkg::REQ_INSERT, 63'd0, '1, '1, 32'd0);
    push_req(tssb_pkg::REQ_LOOKUP, 63'd0, 16'd0, 16'd0, 32'd0);
    drain();

    windows = '{40'd0, '1, 40'd1000, 40'd5000000, tssb_pkg::AGE_RESET};
    for (p = 0; p < 5; p++) begin
      // sender waits for the block to drain before each new window
      tx_hold <= 1'b1;
      write_window(windows[p]);
      base_stamp = 63'd1_000_000_000_000 + p * 63'd1_000_000;
      recent_stamps.delete();
      for (k = 0; k < 240; k++) request_q.push_back(random_request());
      @(posedge clk);
      no_idle <= (p == 3);
      tx_hold <= 1'b0;
      drain();
    end
    no_idle <= 1'b0;

    if (mismatch_count == 0 && pending_responses.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
